FILE: design/hmscd_pkg.sv
package hmscd_pkg;

	localparam int TimeW = 6;
	localparam int KeyW  = 4;
	localparam int ScrW  = 4;

	localparam logic [TimeW-1:0] TIME_MAX = TimeW'(59);

	// keypad codes
	localparam logic [KeyW-1:0] KEY_A = KeyW'(10);
	localparam logic [KeyW-1:0] KEY_B = KeyW'(11);
	localparam logic [KeyW-1:0] KEY_C = KeyW'(12);
	localparam logic [KeyW-1:0] KEY_D = KeyW'(13);
	localparam logic [KeyW-1:0] KEY_E = KeyW'(14);
	localparam logic [KeyW-1:0] KEY_F = KeyW'(15);
	localparam logic [KeyW-1:0] KEY_DIGIT_MAX = KeyW'(9);
	localparam logic [KeyW-1:0] KEY_TENS_MAX  = KeyW'(5);

	// screen / mode codes
	localparam logic [ScrW-1:0] SCR_MENU    = ScrW'(0);
	localparam logic [ScrW-1:0] SCR_ENT_SU  = ScrW'(1);
	localparam logic [ScrW-1:0] SCR_ENT_ST  = ScrW'(2);
	localparam logic [ScrW-1:0] SCR_ENT_MU  = ScrW'(3);
	localparam logic [ScrW-1:0] SCR_ENT_MT  = ScrW'(4);
	localparam logic [ScrW-1:0] SCR_ENT_HU  = ScrW'(5);
	localparam logic [ScrW-1:0] SCR_ENT_HT  = ScrW'(6);
	localparam logic [ScrW-1:0] SCR_COUNT   = ScrW'(7);
	localparam logic [ScrW-1:0] SCR_TPAUSE  = ScrW'(8);
	localparam logic [ScrW-1:0] SCR_DONE    = ScrW'(9);
	localparam logic [ScrW-1:0] SCR_SWREADY = ScrW'(10);
	localparam logic [ScrW-1:0] SCR_SWRUN   = ScrW'(11);
	localparam logic [ScrW-1:0] SCR_SWPAUSE = ScrW'(12);

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_KEY  = 1'b1;

	typedef struct packed {
		logic            op;
		logic [KeyW-1:0] key_code;
	} evt_t;

	typedef struct packed {
		logic [TimeW-1:0] hours_now;
		logic [TimeW-1:0] minutes_now;
		logic [TimeW-1:0] seconds_now;
		logic [ScrW-1:0]  screen;
		logic             done_pulse;
	} disp_t;

	typedef struct packed {
		logic [ScrW-1:0]  mode;
		logic [TimeW-1:0] hours;
		logic [TimeW-1:0] minutes;
		logic [TimeW-1:0] seconds;
	} clk_state_t;

endpackage

FILE: design/hms_countdown_stopwatch_controller.sv
//  channel | dir | handshake              | payload
//  evt     | in  | evt_valid / evt_stall  | evt_t  : op, key_code
//  disp    | out | disp_valid / disp_stall| disp_t : h, m, s, screen, done_pulse
//
//  One event a cycle sustained while disp is not stalled. An accepted event is
//  held in the input stage, then applied to the mode and time registers and the
//  disp result register, whose beat then appears on disp.
//  arst_n clears the mode to the menu and the time to 00:00:00.
//  A stalled disp beat holds; evt stalls only while both stages are full and
//  disp is stalled.
module hms_countdown_stopwatch_controller import hmscd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  evt_valid,
	output logic  evt_stall,
	input  evt_t  evt,
	output logic  disp_valid,
	input  logic  disp_stall,
	output disp_t disp
);

	logic       valid_s1;
	evt_t       evt_s1;
	logic       valid_q;
	disp_t      disp_q;
	clk_state_t state_q;
	clk_state_t state_nxt;
	logic       done_nxt;
	logic       advance;

	// the result register can take a beat when it is empty or being drained
	assign advance   = ~valid_q | ~disp_stall;
	assign evt_stall = valid_s1 & ~advance;

	hmscd_step u_step (
		.cur  (state_q),
		.evt  (evt_s1),
		.nxt  (state_nxt),
		.done (done_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!evt_stall) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!evt_stall && evt_valid)
			evt_s1 <= evt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			state_q.mode <= SCR_MENU;
			state_q.hours   <= '0;
			state_q.minutes <= '0;
			state_q.seconds <= '0;
		end else if (advance) begin
			valid_q <= valid_s1;
			if (valid_s1)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			disp_q.hours_now   <= state_nxt.hours;
			disp_q.minutes_now <= state_nxt.minutes;
			disp_q.seconds_now <= state_nxt.seconds;
			disp_q.screen      <= state_nxt.mode;
			disp_q.done_pulse  <= done_nxt;
		end
	end

	assign disp_valid = valid_q;
	assign disp       = disp_q;

endmodule

FILE: design/hmscd_step.sv
module hmscd_step import hmscd_pkg::*; (
	input  clk_state_t cur,
	input  evt_t       evt,
	output clk_state_t nxt,
	output logic       done
);

	logic             is_key;
	logic             is_tick;
	logic [KeyW-1:0]  key;
	logic [ScrW-1:0]  mode;
	logic             tens;
	logic             digit_ok;
	logic [TimeW-1:0] add;
	logic             all_zero;
	logic             ms_zero;
	logic             all_max;
	logic             ms_max;

	always_comb begin
		is_key  = (evt.op == OP_KEY);
		is_tick = (evt.op == OP_TICK);
		key     = evt.key_code;
		// codes past the last screen fall back to the menu
		mode    = (cur.mode > SCR_SWPAUSE) ? SCR_MENU : cur.mode;

		tens     = ~mode[0];
		digit_ok = tens ? (key <= KEY_TENS_MAX) : (key <= KEY_DIGIT_MAX);
		add      = tens ? (TimeW'({key, 3'b000}) + TimeW'({key, 1'b0})) : TimeW'(key);

		all_zero = (cur.hours == '0) && (cur.minutes == '0) && (cur.seconds == '0);
		ms_zero  = (cur.minutes == '0) && (cur.seconds == '0);
		all_max  = (cur.hours == TIME_MAX) && (cur.minutes == TIME_MAX)
			&& (cur.seconds == TIME_MAX);
		ms_max   = (cur.minutes == TIME_MAX) && (cur.seconds == TIME_MAX);
	end

	always_comb begin
		nxt      = cur;
		nxt.mode = mode;
		done     = 1'b0;
		case (mode)
			SCR_MENU: begin
				if (is_key && key == KEY_A)
					nxt.mode = SCR_ENT_SU;
				else if (is_key && key == KEY_B)
					nxt.mode = SCR_SWREADY;
			end
			SCR_ENT_SU, SCR_ENT_ST, SCR_ENT_MU, SCR_ENT_MT, SCR_ENT_HU, SCR_ENT_HT: begin
				if (is_key && digit_ok) begin
					if (mode <= SCR_ENT_ST)
						nxt.seconds = cur.seconds + add;
					else if (mode <= SCR_ENT_MT)
						nxt.minutes = cur.minutes + add;
					else
						nxt.hours = cur.hours + add;
					nxt.mode = (mode == SCR_ENT_HT) ? SCR_COUNT : mode + ScrW'(1);
				end
			end
			SCR_COUNT: begin
				if (is_key) begin
					if (key == KEY_F)
						nxt.mode = SCR_TPAUSE;
				end else if (all_zero) begin
					nxt.mode = SCR_DONE;
					done     = 1'b1;
				end else if (ms_zero) begin
					nxt.hours   = cur.hours - TimeW'(1);
					nxt.minutes = TIME_MAX;
					nxt.seconds = TIME_MAX;
				end else if (cur.seconds == '0) begin
					nxt.minutes = cur.minutes - TimeW'(1);
					nxt.seconds = TIME_MAX;
				end else begin
					nxt.seconds = cur.seconds - TimeW'(1);
				end
			end
			SCR_TPAUSE, SCR_SWPAUSE: begin
				if (is_key && key == KEY_E) begin
					nxt.mode = (mode == SCR_TPAUSE) ? SCR_COUNT : SCR_SWRUN;
				end else if (is_key && key == KEY_D) begin
					nxt.mode    = SCR_MENU;
					nxt.hours   = '0;
					nxt.minutes = '0;
					nxt.seconds = '0;
				end
			end
			SCR_DONE: begin
				if (is_key && key == KEY_C)
					nxt.mode = SCR_MENU;
			end
			SCR_SWREADY: begin
				if (is_key && key == KEY_E)
					nxt.mode = SCR_SWRUN;
			end
			SCR_SWRUN: begin
				if (is_key) begin
					if (key == KEY_F)
						nxt.mode = SCR_SWPAUSE;
				end else if (all_max) begin
					nxt.mode    = SCR_MENU;
					nxt.hours   = '0;
					nxt.minutes = '0;
					nxt.seconds = '0;
				end else if (ms_max) begin
					nxt.hours   = cur.hours + TimeW'(1);
					nxt.minutes = '0;
					nxt.seconds = '0;
				end else if (cur.seconds == TIME_MAX) begin
					nxt.minutes = cur.minutes + TimeW'(1);
					nxt.seconds = '0;
				end else begin
					nxt.seconds = cur.seconds + TimeW'(1);
				end
			end
			default: begin
				nxt.mode = SCR_MENU;
			end
		endcase
		// an unused tick leaves everything as is
		if (is_tick && mode != SCR_COUNT && mode != SCR_SWRUN)
			nxt.mode = mode;
	end

endmodule

FILE: design/hmscd_checker.sv
module hmscd_checker import hmscd_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  evt_stall,
	input logic  disp_valid,
	input logic  disp_stall,
	input disp_t disp
);

	// completion is only ever flagged on the complete screen
	a_done_screen: assert property (@(posedge clk) disable iff (!arst_n)
		disp_valid && disp.done_pulse |-> disp.screen == SCR_DONE)
		else $error("done_pulse outside complete screen");

	// time fields never leave 0..59
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		disp_valid |-> disp.hours_now <= TIME_MAX && disp.minutes_now <= TIME_MAX
			&& disp.seconds_now <= TIME_MAX)
		else $error("time field out of range");

	// with nothing pending on disp the input side must not stall
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!disp_valid |-> !evt_stall)
		else $error("evt stalled with empty output");

	// done is a pulse: the beat after it leaves complete shows no new done
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		disp_valid && !disp_stall && disp.done_pulse ##1 disp_valid
			|-> !disp.done_pulse)
		else $error("done_pulse repeated");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		disp_valid && disp_stall |=> disp_valid && $stable(disp))
		else $error("stalled disp beat changed");

endmodule

bind hms_countdown_stopwatch_controller hmscd_checker u_hmscd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.evt_stall  (evt_stall),
	.disp_valid (disp_valid),
	.disp_stall (disp_stall),
	.disp       (disp)
);
